// File: sv/cct_pkg.sv
// Shared types, constants and the character classifier of the tokenizer.
`default_nettype none

package cct_pkg;

  localparam int MAX_WORD_LEN_DEF = 32;
  localparam int QDEPTH           = 4;
  localparam int QPTR_W           = $clog2(QDEPTH);
  localparam int QCNT_W           = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [31:0] KW_COOK = "cook";
  localparam logic [31:0] KW_TERM = "Term";
  localparam logic [31:0] KW_CALC = "calc";
  localparam logic [31:0] KW_FRAC = "frac";

  typedef enum logic [3:0] {
    KIND_NAME    = 4'd0,
    KIND_NUMBER  = 4'd1,
    KIND_COOK    = 4'd2,
    KIND_TERM    = 4'd3,
    KIND_CALC    = 4'd4,
    KIND_FRAC    = 4'd5,
    KIND_BSLASH  = 4'd6,
    KIND_LBRACE  = 4'd7,
    KIND_RBRACE  = 4'd8,
    KIND_LPAREN  = 4'd9,
    KIND_RPAREN  = 4'd10,
    KIND_MULDIV  = 4'd11,
    KIND_ADDSUB  = 4'd12,
    KIND_EQUALS  = 4'd13,
    KIND_SEMI    = 4'd14,
    KIND_ERROR   = 4'd15
  } kind_t;

  typedef enum logic [2:0] {
    CAT_LETTER = 3'd0,
    CAT_DIGIT  = 3'd1,
    CAT_SPACE  = 3'd2,
    CAT_SYMBOL = 3'd3,
    CAT_ERROR  = 3'd4
  } cat_t;

  // One classified character as it travels from the front to the back.
  typedef struct packed {
    cat_t       cat;
    kind_t      kind;
    logic [7:0] ch;
  } item_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
  } q_stat_t;

  function automatic item_t classify(input logic [7:0] c);
    item_t it;
    it.ch   = c;
    it.kind = KIND_ERROR;
    it.cat  = CAT_SYMBOL;
    case (c) inside
      CH_SPACE, CH_LF:                          it.cat = CAT_SPACE;
      [8'h61:8'h7a], [8'h41:8'h5a], 8'h5f:      it.cat = CAT_LETTER;
      [8'h30:8'h39], 8'h2e:                     it.cat = CAT_DIGIT;
      8'h5c:                                    it.kind = KIND_BSLASH;
      8'h7b:                                    it.kind = KIND_LBRACE;
      8'h7d:                                    it.kind = KIND_RBRACE;
      8'h28:                                    it.kind = KIND_LPAREN;
      8'h29:                                    it.kind = KIND_RPAREN;
      8'h2a, 8'h2f:                             it.kind = KIND_MULDIV;
      8'h2d, 8'h2b:                             it.kind = KIND_ADDSUB;
      8'h3d:                                    it.kind = KIND_EQUALS;
      8'h3b:                                    it.kind = KIND_SEMI;
      default:                                  it.cat = CAT_ERROR;
    endcase
    return it;
  endfunction

endpackage

`default_nettype wire

// File: sv/cct_if.sv
// Valid/ready channel interfaces for source characters and tokens.
`default_nettype none

interface cct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink   (input valid, input in_char, output ready);
endinterface

interface cct_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_kind;
  logic [7:0] token_char;
  logic       last_of_token;
  logic       truncated;
  logic       last_of_run;

  modport source (output valid, output token_kind, output token_char,
                  output last_of_token, output truncated, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input token_char,
                  input last_of_token, input truncated, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

// File: sv/char_class_tokenizer.sv
// Top level of the character-class tokenizer: front, queue, back and checks.
//
// Takes one source byte per transaction and returns tokens one character per
// transaction. The front classifies a byte in the cycle it arrives and pushes
// it into a four-entry queue, so input runs at one byte per cycle until the
// queue fills. The back drains the queue: a letter or digit is added to the
// word; a space or symbol that ends a word starts a flush, which reads it
// out of the registered word buffer one character at a time, and a symbol
// then gets its own token. A flush holds the back while the front keeps
// filling the queue. A byte outside every class produces one error token;
// after it every input is accepted and dropped until reset. Words longer than
// MAX_WORD_LEN keep their first characters and carry the truncated flag, and
// such a word is never a keyword.
`default_nettype none

module char_class_tokenizer import cct_pkg::*; #(
  parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cct_in_if.sink    in_ch,
  cct_out_if.source out_tok
);

  item_t   push_item, pop_item;
  logic    push_valid, push_ready, pop_valid, pop_ready;
  q_stat_t q_stat;

  // Classify and gate on the sticky error.
  cct_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // Decouple the front from word flushes.
  cct_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_item   (pop_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .stat       (q_stat)
  );

  // Build words and emit token runs.
  cct_back #(
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_item  (pop_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .out_tok   (out_tok)
  );

  // Queue occupancy never passes its depth, and full agrees with the count.
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.count <= QCNT_W'(QDEPTH)) && (q_stat.full == (q_stat.count == QCNT_W'(QDEPTH))))
    else $error("queue count out of range");

  // Nothing follows an error token once it has been taken.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tok.valid && out_tok.ready && out_tok.token_kind == KIND_ERROR |=> !out_tok.valid)
    else $error("token after error");

  // A run only ends on the last character of a token.
  a_run_tok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tok.valid && out_tok.last_of_run |-> out_tok.last_of_token)
    else $error("run ends inside a token");

  // Only name and number tokens can be truncated.
  a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tok.valid && out_tok.truncated |->
      (out_tok.token_kind == KIND_NAME || out_tok.token_kind == KIND_NUMBER))
    else $error("truncated flag on non-word token");

endmodule

`default_nettype wire

// File: sv/cct_front.sv
// Front end: accepts characters, classifies them and drops input after an error.
`default_nettype none

module cct_front import cct_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  cct_in_if.sink    in_ch,
  output item_t     push_item,
  output logic      push_valid,
  input  wire logic push_ready
);

  logic  err_r;
  logic  err_nxt;
  item_t cls;

  assign cls        = classify(in_ch.in_char);
  assign push_item  = cls;
  // After an error every character is taken and dropped.
  assign in_ch.ready = err_r | push_ready;
  assign push_valid  = in_ch.valid & ~err_r;

  always_comb begin
    err_nxt = err_r;
    if (push_valid && push_ready && cls.cat == CAT_ERROR) begin
      err_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r <= 1'b0;
    end else begin
      err_r <= err_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/cct_queue.sv
// Small FIFO of classified characters between front and back.
`default_nettype none

module cct_queue import cct_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire item_t push_item,
  input  wire logic push_valid,
  output logic      push_ready,
  output item_t     pop_item,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output q_stat_t   stat
);

  item_t             slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push, pop;

  assign push_ready = cnt_r != QCNT_W'(QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = slot_r[rd_ptr_r];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;
  assign stat.count = cnt_r;
  assign stat.full  = ~push_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/cct_back.sv
// Back end: builds words in a buffer and emits token runs through an output register.
`default_nettype none

module cct_back import cct_pkg::*; #(
  parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire item_t pop_item,
  input  wire logic pop_valid,
  output logic      pop_ready,
  cct_out_if.source out_tok
);

  localparam int AW    = $clog2(MAX_WORD_LEN);
  localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WORD = 3'b010,
    ST_SYM  = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [7:0]       mem [MAX_WORD_LEN];
  logic [7:0]       rd_data_r;
  logic [7:0]       head_r [4];
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic             ovf_r, ovf_nxt;
  logic             dig_r, dig_nxt;
  kind_t            kind_r, kind_nxt;
  kind_t            sym_kind_r, sym_kind_nxt;
  logic [7:0]       sym_char_r, sym_char_nxt;
  logic             sym_pend_r, sym_pend_nxt;

  logic             wr_en, rd_en, head_wr;
  logic [AW-1:0]    rd_addr;
  logic             fire, last_char, pop;
  kind_t            word_kind;

  logic             ov_r, ov_nxt;
  kind_t            o_kind_r, o_kind_nxt;
  logic [7:0]       o_char_r, o_char_nxt;
  logic             o_lt_r, o_lt_nxt, o_tr_r, o_tr_nxt, o_lr_r, o_lr_nxt;

  assign pop_ready = state_r == ST_IDLE;
  assign pop       = pop_valid & pop_ready;
  assign fire      = ~ov_r | out_tok.ready;
  assign last_char = (LEN_W'(idx_r) + LEN_W'(1)) == len_r;
  assign wr_en     = pop && (pop_item.cat == CAT_LETTER || pop_item.cat == CAT_DIGIT) &&
                     len_r < LEN_W'(MAX_WORD_LEN);
  assign head_wr   = wr_en && len_r < LEN_W'(4);

  // Keyword match needs exactly four held characters and no truncation.
  always_comb begin
    word_kind = dig_r ? KIND_NUMBER : KIND_NAME;
    if (!ovf_r && len_r == LEN_W'(4)) begin
      case ({head_r[0], head_r[1], head_r[2], head_r[3]})
        KW_COOK: word_kind = KIND_COOK;
        KW_TERM: word_kind = KIND_TERM;
        KW_CALC: word_kind = KIND_CALC;
        KW_FRAC: word_kind = KIND_FRAC;
        default: word_kind = dig_r ? KIND_NUMBER : KIND_NAME;
      endcase
    end
  end

  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    idx_nxt      = idx_r;
    ovf_nxt      = ovf_r;
    dig_nxt      = dig_r;
    kind_nxt     = kind_r;
    sym_kind_nxt = sym_kind_r;
    sym_char_nxt = sym_char_r;
    sym_pend_nxt = sym_pend_r;
    rd_en        = 1'b0;
    rd_addr      = '0;
    ov_nxt       = ov_r & ~out_tok.ready;
    o_kind_nxt   = o_kind_r;
    o_char_nxt   = o_char_r;
    o_lt_nxt     = o_lt_r;
    o_tr_nxt     = o_tr_r;
    o_lr_nxt     = o_lr_r;

    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          sym_kind_nxt = pop_item.kind;
          sym_char_nxt = pop_item.ch;
          sym_pend_nxt = pop_item.cat == CAT_SYMBOL;
          case (pop_item.cat)
            CAT_LETTER, CAT_DIGIT: begin
              if (len_r < LEN_W'(MAX_WORD_LEN)) begin
                len_nxt = len_r + LEN_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
              dig_nxt = pop_item.cat == CAT_DIGIT;
            end
            CAT_ERROR: begin
              // Discard the pending word, report the byte.
              len_nxt   = '0;
              ovf_nxt   = 1'b0;
              dig_nxt   = 1'b0;
              state_nxt = ST_SYM;
            end
            CAT_SPACE, CAT_SYMBOL: begin
              if (len_r != '0) begin
                kind_nxt  = word_kind;
                idx_nxt   = '0;
                rd_en     = 1'b1;
                state_nxt = ST_WORD;
              end else begin
                ovf_nxt = 1'b0;
                dig_nxt = 1'b0;
                if (pop_item.cat == CAT_SYMBOL) begin
                  state_nxt = ST_SYM;
                end
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_WORD: begin
        if (fire) begin
          ov_nxt     = 1'b1;
          o_kind_nxt = kind_r;
          o_char_nxt = rd_data_r;
          o_lt_nxt   = last_char;
          o_tr_nxt   = ovf_r;
          o_lr_nxt   = last_char & ~sym_pend_r;
          if (last_char) begin
            len_nxt   = '0;
            ovf_nxt   = 1'b0;
            dig_nxt   = 1'b0;
            state_nxt = sym_pend_r ? ST_SYM : ST_IDLE;
          end else begin
            idx_nxt = idx_r + AW'(1);
            rd_en   = 1'b1;
            rd_addr = idx_r + AW'(1);
          end
        end
      end
      ST_SYM: begin
        if (fire) begin
          ov_nxt     = 1'b1;
          o_kind_nxt = sym_kind_r;
          o_char_nxt = sym_char_r;
          o_lt_nxt   = 1'b1;
          o_tr_nxt   = 1'b0;
          o_lr_nxt   = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[len_r[AW-1:0]] <= pop_item.ch;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (head_wr) begin
      head_r[len_r[1:0]] <= pop_item.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      len_r      <= '0;
      ovf_r      <= 1'b0;
      dig_r      <= 1'b0;
      sym_pend_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      len_r      <= len_nxt;
      ovf_r      <= ovf_nxt;
      dig_r      <= dig_nxt;
      sym_pend_r <= sym_pend_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    kind_r     <= kind_nxt;
    sym_kind_r <= sym_kind_nxt;
    sym_char_r <= sym_char_nxt;
    o_kind_r   <= o_kind_nxt;
    o_char_r   <= o_char_nxt;
    o_lt_r     <= o_lt_nxt;
    o_tr_r     <= o_tr_nxt;
    o_lr_r     <= o_lr_nxt;
  end

  assign out_tok.valid         = ov_r;
  assign out_tok.token_kind    = o_kind_r;
  assign out_tok.token_char    = o_char_r;
  assign out_tok.last_of_token = o_lt_r;
  assign out_tok.truncated     = o_tr_r;
  assign out_tok.last_of_run   = o_lr_r;

endmodule

`default_nettype wire

// File: dv/char_class_tokenizer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for char_class_tokenizer: directed and random character streams.
module char_class_tokenizer_tb;
  import cct_pkg::*;

  localparam int WORD_MAX = MAX_WORD_LEN_DEF;
  // Cycles of silence demanded once nothing is awaited: longest flush plus queue slack.
  localparam int SETTLE_CYCLES = 2 * WORD_MAX + 40;

  // One token character as it should appear on the result channel.
  typedef struct {
    kind_t      kind;
    logic [7:0] ch;
    logic       last_tok;
    logic       trunc;
    logic       last_run;
  } token_char_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cct_in_if  in_ch ();
  cct_out_if out_tok ();

  char_class_tokenizer #(.MAX_WORD_LEN(WORD_MAX)) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_tok (out_tok)
  );

  always #2 clk = ~clk;

  // Mirror of the tokenizer state, advanced on every accepted character.
  logic [7:0]  word_buf [WORD_MAX];
  int          word_len;
  bit          word_trunc;
  bit          word_numeric;
  bit          stuck_error;
  token_char_t awaited_tokens [$];

  int fails;
  int idle_odds;   // 0 disables idling; otherwise one chance in idle_odds per step
  int stall_left;
  int chars_sent;

  logic [7:0] delims [13] = '{" ", "\n", "\\", "{", "}", "(", ")", "*", "/", "-", "+",
                              "=", ";"};
  string keywords [4] = '{"cook", "Term", "calc", "frac"};

  // Map a symbol byte to its token kind; anything else reports the error kind.
  function automatic kind_t sym_kind(input logic [7:0] c);
    case (c)
      "\\":     return KIND_BSLASH;
      "{":      return KIND_LBRACE;
      "}":      return KIND_RBRACE;
      "(":      return KIND_LPAREN;
      ")":      return KIND_RPAREN;
      "*", "/": return KIND_MULDIV;
      "-", "+": return KIND_ADDSUB;
      "=":      return KIND_EQUALS;
      ";":      return KIND_SEMI;
      default:  return KIND_ERROR;
    endcase
  endfunction

  function automatic cat_t char_cat(input logic [7:0] c);
    if (c == CH_SPACE || c == CH_LF) return CAT_SPACE;
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") return CAT_LETTER;
    if ((c >= "0" && c <= "9") || c == ".") return CAT_DIGIT;
    if (sym_kind(c) != KIND_ERROR) return CAT_SYMBOL;
    return CAT_ERROR;
  endfunction

  function automatic void clear_word();
    word_len     = 0;
    word_trunc   = 1'b0;
    word_numeric = 1'b0;
  endfunction

  // Append the pending word, one entry per kept character, then empty the buffer.
  function automatic void emit_word(ref token_char_t run [$]);
    kind_t       k;
    logic [31:0] text;
    if (word_len == 0) begin
      clear_word();
      return;
    end
    k = word_numeric ? KIND_NUMBER : KIND_NAME;
    // Only an intact four-character word can be a keyword.
    if (!word_trunc && word_len == 4) begin
      text = {word_buf[0], word_buf[1], word_buf[2], word_buf[3]};
      if (text == KW_COOK) k = KIND_COOK;
      else if (text == KW_TERM) k = KIND_TERM;
      else if (text == KW_CALC) k = KIND_CALC;
      else if (text == KW_FRAC) k = KIND_FRAC;
    end
    for (int i = 0; i < word_len; i++)
      run.insert(run.size(), '{k, word_buf[i], i == word_len - 1, word_trunc, 1'b0});
    clear_word();
  endfunction

  // Advance the mirror by one character and queue the token characters it causes.
  function automatic void tokenize_char(input logic [7:0] c);
    token_char_t run [$];
    cat_t        cat;
    if (stuck_error) return;
    cat = char_cat(c);
    if (cat == CAT_LETTER || cat == CAT_DIGIT) begin
      // A full buffer drops the character but it still decides number versus name.
      if (word_len < WORD_MAX) begin
        word_buf[word_len] = c;
        word_len++;
      end else begin
        word_trunc = 1'b1;
      end
      word_numeric = (cat == CAT_DIGIT);
      return;
    end
    if (cat == CAT_ERROR) begin
      // Discard the pending word silently and lock up until reset.
      clear_word();
      stuck_error = 1'b1;
      run.insert(run.size(), '{KIND_ERROR, c, 1'b1, 1'b0, 1'b0});
    end else begin
      emit_word(run);
      if (cat == CAT_SYMBOL) run.insert(run.size(), '{sym_kind(c), c, 1'b1, 1'b0, 1'b0});
    end
    if (run.size() > 0) run[run.size() - 1].last_run = 1'b1;
    foreach (run[i]) awaited_tokens.insert(awaited_tokens.size(), run[i]);
  endfunction

  // Predict on every accepted character, check every accepted token character.
  always @(posedge clk) begin : score
    token_char_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) tokenize_char(in_ch.in_char);
      if (out_tok.valid && out_tok.ready) begin
        if (awaited_tokens.size() == 0) begin
          $error("token with nothing awaited: kind %0d char 0x%02h",
                 out_tok.token_kind, out_tok.token_char);
          fails++;
        end else begin
          want = awaited_tokens.pop_front();
          if (out_tok.token_kind !== want.kind) begin
            $error("token_kind: expected %0d, actual %0d", want.kind, out_tok.token_kind);
            fails++;
          end
          if (out_tok.token_char !== want.ch) begin
            $error("token_char: expected 0x%02h, actual 0x%02h", want.ch, out_tok.token_char);
            fails++;
          end
          if (out_tok.last_of_token !== want.last_tok) begin
            $error("last_of_token: expected %0b, actual %0b", want.last_tok,
                   out_tok.last_of_token);
            fails++;
          end
          if (out_tok.truncated !== want.trunc) begin
            $error("truncated: expected %0b, actual %0b", want.trunc, out_tok.truncated);
            fails++;
          end
          if (out_tok.last_of_run !== want.last_run) begin
            $error("last_of_run: expected %0b, actual %0b", want.last_run,
                   out_tok.last_of_run);
            fails++;
          end
        end
      end
    end
  end

  // Receiver: stall in random bursts while idling is enabled.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left      <= stall_left - 1;
      out_tok.ready   <= 1'b0;
    end else if (idle_odds > 0 && $urandom_range(0, idle_odds - 1) == 0) begin
      stall_left      <= $urandom_range(1, 11) - 1;
      out_tok.ready   <= 1'b0;
    end else begin
      out_tok.ready   <= 1'b1;
    end
  end

  // Offer one character, maybe after a random gap, and hold it until accepted.
  // Valid stays high after acceptance so back-to-back characters see no bubble.
  task automatic send_char(input logic [7:0] c);
    int gap;
    if (idle_odds > 0 && $urandom_range(0, idle_odds - 1) == 0) begin
      gap = $urandom_range(1, 11);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_char <= c;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Drop valid and hold off until every awaited token character has arrived.
  // The first edge lets the last accepted character reach the mirror.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_tokens.size() > 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_word_char();
    case ($urandom_range(0, 4))
      0:       return 8'("a" + $urandom_range(0, 25));
      1:       return 8'("A" + $urandom_range(0, 25));
      2:       return "_";
      3:       return 8'("0" + $urandom_range(0, 9));
      default: return ".";
    endcase
  endfunction

  function automatic logic [7:0] rand_delim();
    return delims[$urandom_range(0, 12)];
  endfunction

  // Mostly words ended by a delimiter; the rest is bare delimiters as noise.
  task automatic random_stream(input int count);
    int stop_at;
    int len;
    stop_at = chars_sent + count;
    while (chars_sent < stop_at) begin
      if ($urandom_range(0, 99) < 75) begin
        case ($urandom_range(0, 19))
          0, 1, 2: send_text(keywords[$urandom_range(0, 3)]);
          3:       begin
                     len = $urandom_range(WORD_MAX - 2, WORD_MAX + 8);
                     repeat (len) send_char(rand_word_char());
                   end
          default: begin
                     len = $urandom_range(1, 8);
                     repeat (len) send_char(rand_word_char());
                   end
        endcase
        send_char(rand_delim());
      end else begin
        repeat ($urandom_range(1, 3)) send_char(rand_delim());
      end
    end
  endtask

  // Four keywords, each closed by a bracket symbol.
  task automatic test_keywords();
    idle_odds = 4;
    send_text("cook{Term}calc(frac)");
  endtask

  // Remaining symbols with no word pending: symbol token only.
  task automatic test_symbols();
    send_text("\\*/-+=;");
  endtask

  // Number ending in a period, name, empty flush on a double space, number by symbol.
  task automatic test_word_ends();
    send_text("1.\na1b  x9;");
    drain();
  endtask

  // Overfill the buffer; the dropped final digit still makes it a number.
  task automatic test_truncation();
    idle_odds = 3;
    repeat (WORD_MAX) send_char("q");
    send_char("5");
    send_char(";");
    drain();
  endtask

  // Random phases: idling, a stretch without it, idling again, a pause to drain, then calm to the end.
  task automatic test_random();
    idle_odds = 3;
    random_stream(60);
    idle_odds = 0;
    random_stream(40);
    idle_odds = 2;
    random_stream(60);
    drain();
    idle_odds = 0;
    random_stream(40);
  endtask

  // Unknown byte kills the pending word; everything afterwards is swallowed.
  task automatic test_error();
    idle_odds = 0;
    send_text("ab");
    send_char(8'hff);
    send_char(8'h00);
    send_text("cook ;");
    repeat (12) send_char(8'($urandom_range(0, 255)));
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.in_char = 8'h00;
    out_tok.ready = 1'b0;
    fails         = 0;
    idle_odds     = 0;
    stall_left    = 0;
    chars_sent    = 0;
    stuck_error   = 1'b0;
    clear_word();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_keywords();
    test_symbols();
    test_word_ends();
    test_truncation();
    test_random();
    test_error();

    // Wait out the last flush, then make sure nothing stray follows.
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #3200000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: char_class_tokenizer.f
sv/cct_pkg.sv
sv/cct_if.sv
sv/cct_front.sv
sv/cct_queue.sv
sv/cct_back.sv
sv/char_class_tokenizer.sv
dv/char_class_tokenizer_tb.sv
